### rtl/dmct_pkg.sv
// shared types, constants and helpers for the direct-mapped cache tracker
package dmct_pkg;

  localparam int LINES_DEF       = 1024;
  localparam int ADDR_WIDTH_DEF  = 32;
  localparam int ADDR_W          = 32;
  localparam int TAG_W           = 32;
  localparam int COUNT_W         = 32;
  localparam int CFG_DATA_W      = 4;
  localparam int CFG_INDEX_W     = 2;
  localparam logic [3:0] MAX_OFFSET_BITS = 4'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OFFSET_BITS   = 2'd0,
    CFG_INDEX_BITS    = 2'd1,
    CFG_WRITE_THROUGH = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
  } access_t;

  typedef struct packed {
    logic               hit;
    logic               memory_read;
    logic               memory_write;
    logic [COUNT_W-1:0] read_total;
    logic [COUNT_W-1:0] write_total;
    logic [COUNT_W-1:0] hit_total;
    logic [COUNT_W-1:0] miss_total;
  } result_t;

  // one line of the store
  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } line_t;

  // per-access counter increments
  typedef struct packed {
    logic       hit;
    logic       miss;
    logic       read;
    logic [1:0] writes;
  } cnt_inc_t;

  typedef struct packed {
    logic [COUNT_W-1:0] reads;
    logic [COUNT_W-1:0] writes;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] misses;
  } totals_t;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] c,
                                                 input logic [1:0] n);
    logic [COUNT_W:0] s;
    s = {1'b0, c} + (COUNT_W+1)'(n);
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

endpackage

### rtl/dmct_addr_split.sv
// splits a byte address into set index and tag by the configured bit counts
module dmct_addr_split #(
  parameter int LINES      = dmct_pkg::LINES_DEF,
  parameter int ADDR_WIDTH = dmct_pkg::ADDR_WIDTH_DEF
) (
  input  logic [dmct_pkg::ADDR_W-1:0]          address,
  input  logic [3:0]                           offset_bits,
  input  logic [3:0]                           index_bits,
  output logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] set_idx,
  output logic [dmct_pkg::TAG_W-1:0]           tag
);

  localparam int IDX_W  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int IB_MAX = $clog2(LINES + 1) - 1;
  localparam logic [dmct_pkg::ADDR_W-1:0] AMASK = (ADDR_WIDTH >= dmct_pkg::ADDR_W) ?
      {dmct_pkg::ADDR_W{1'b1}} :
      dmct_pkg::ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

  logic [dmct_pkg::ADDR_W-1:0] addr_m;
  logic [dmct_pkg::ADDR_W-1:0] above;
  logic [dmct_pkg::ADDR_W-1:0] set_mask;
  logic [dmct_pkg::ADDR_W-1:0] set_full;
  logic [3:0]                  ob;
  logic [3:0]                  ib;
  logic [4:0]                  shift_total;

  always_comb begin
    addr_m      = address & AMASK;
    // oversized counts clamp
    ob          = (offset_bits > dmct_pkg::MAX_OFFSET_BITS) ? dmct_pkg::MAX_OFFSET_BITS
                                                           : offset_bits;
    ib          = ({1'b0, index_bits} > 5'(IB_MAX)) ? 4'(IB_MAX) : index_bits;
    above       = addr_m >> ob;
    set_mask    = (dmct_pkg::ADDR_W'(1) << ib) - dmct_pkg::ADDR_W'(1);
    set_full    = above & set_mask;
    set_idx     = set_full[IDX_W-1:0];
    shift_total = {1'b0, ob} + {1'b0, ib};
    tag         = dmct_pkg::TAG_W'(addr_m >> shift_total);
  end

endmodule

### rtl/dmct_line_store.sv
// line store memory holding valid, dirty and tag, with a clearing pass after reset
module dmct_line_store #(
  parameter int LINES = dmct_pkg::LINES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] rd_idx,
  output dmct_pkg::line_t       rd_data,
  input  logic                  wr_en,
  input  logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] wr_idx,
  input  dmct_pkg::line_t       wr_data,
  output logic                  clearing
);

  localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

  dmct_pkg::line_t mem [LINES];
  logic [IDX_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == IDX_W'(LINES - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

### rtl/dmct_counters.sv
// saturating traffic and hit/miss totals
module dmct_counters (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  dmct_pkg::cnt_inc_t inc,
  output dmct_pkg::totals_t  totals_next
);

  dmct_pkg::totals_t totals;

  always_comb begin
    totals_next.reads  = dmct_pkg::sat_add(totals.reads, {1'b0, inc.read});
    totals_next.writes = dmct_pkg::sat_add(totals.writes, inc.writes);
    totals_next.hits   = dmct_pkg::sat_add(totals.hits, {1'b0, inc.hit});
    totals_next.misses = dmct_pkg::sat_add(totals.misses, {1'b0, inc.miss});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      totals <= '0;
    end else if (en) begin
      totals <= totals_next;
    end
  end

endmodule

### rtl/direct_mapped_cache_tracker_unit.sv
// top level of the direct-mapped cache tracker
// Direct-mapped cache tracker: each access item (read or write to a byte address) is split into
// block offset, set index and tag using offset_bits and index_bits, looked up in a line store
// of LINES entries (valid, dirty, tag), and answered with one result item carrying hit,
// memory_read, memory_write and four saturating 32-bit totals. write_through selects
// write-through (every write goes to memory) or write-back (writes mark the line dirty and a
// dirty victim is written back on eviction). An item goes through the synchronous read of the
// line store and then a step that compares, updates and writes the line back; no new item is
// taken until the current one commits, and commit waits while an earlier result is not taken.
// After reset the line store is swept clear one entry per cycle, during which no access is
// taken; configuration writes are taken at any time and must only be issued while idle.
module direct_mapped_cache_tracker_unit #(
  parameter int LINES      = dmct_pkg::LINES_DEF,
  parameter int ADDR_WIDTH = dmct_pkg::ADDR_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             access_valid,
  output logic                             access_ready,
  input  dmct_pkg::access_t                access,
  output logic                             result_valid,
  input  logic                             result_ready,
  output dmct_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dmct_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dmct_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t state;

  // configuration registers
  logic [3:0] offset_bits;
  logic [3:0] index_bits;
  logic       write_through;

  // access held while the line is read
  logic [IDX_W-1:0]             set_q;
  logic [dmct_pkg::TAG_W-1:0]   tag_q;
  logic                         is_write_q;

  logic [IDX_W-1:0]             set_idx;
  logic [dmct_pkg::TAG_W-1:0]   tag;
  logic                         accept;
  logic                         commit;
  logic                         clearing;

  dmct_pkg::line_t   line_rd;
  dmct_pkg::line_t   line_wr;
  dmct_pkg::cnt_inc_t inc;
  dmct_pkg::totals_t totals_next;

  logic hit;
  logic evict_wr;
  logic through_wr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits   <= 4'd2;
      index_bits    <= 4'd4;
      write_through <= 1'b0;
    end else if (cfg_valid) begin
      case (dmct_pkg::cfg_reg_t'(cfg_index))
        dmct_pkg::CFG_OFFSET_BITS:   offset_bits   <= cfg_data;
        dmct_pkg::CFG_INDEX_BITS:    index_bits    <= cfg_data;
        dmct_pkg::CFG_WRITE_THROUGH: write_through <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dmct_addr_split #(
    .LINES      (LINES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_split (
    .address     (access.address),
    .offset_bits (offset_bits),
    .index_bits  (index_bits),
    .set_idx     (set_idx),
    .tag         (tag)
  );

  // one item in flight; the line read issues at accept
  assign access_ready = (state == ST_IDLE) && !clearing;
  assign accept       = access_valid && access_ready;
  assign commit       = (state == ST_LOOK) && (!result_valid || result_ready);

  dmct_line_store #(
    .LINES (LINES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_idx   (set_idx),
    .rd_data  (line_rd),
    .wr_en    (commit),
    .wr_idx   (set_q),
    .wr_data  (line_wr),
    .clearing (clearing)
  );

  // hit/miss decision and line update
  always_comb begin
    hit        = line_rd.valid && (line_rd.tag == tag_q);
    evict_wr   = !hit && line_rd.valid && line_rd.dirty;
    through_wr = is_write_q && write_through;

    line_wr.valid = 1'b1;
    line_wr.tag   = tag_q;
    // write-through leaves an existing dirty mark in place
    line_wr.dirty = (hit && line_rd.dirty) || (is_write_q && !write_through);

    inc.hit    = hit;
    inc.miss   = !hit;
    inc.read   = !hit;
    inc.writes = {1'b0, evict_wr} + {1'b0, through_wr};
  end

  dmct_counters u_counters (
    .clk         (clk),
    .rst         (rst),
    .en          (commit),
    .inc         (inc),
    .totals_next (totals_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (commit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (accept) begin
      set_q      <= set_idx;
      tag_q      <= tag;
      is_write_q <= (dmct_pkg::cmd_t'(access.command) == dmct_pkg::CMD_WRITE);
    end
    if (commit) begin
      result.hit          <= hit;
      result.memory_read  <= !hit;
      result.memory_write <= evict_wr || through_wr;
      result.read_total   <= totals_next.reads;
      result.write_total  <= totals_next.writes;
      result.hit_total    <= totals_next.hits;
      result.miss_total   <= totals_next.misses;
    end
  end

  // access is not ready in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !access_ready)
    else $error("access taken while lookup pending");

  // no access during the clearing pass
  a_no_access_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !access_ready)
    else $error("access ready during clearing pass");

  // every result is exactly one of hit or fetch
  a_hit_xor_fetch: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.hit != result.memory_read))
    else $error("hit and memory read disagree");

  // a completed lookup always yields a result next cycle
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> result_valid)
    else $error("lookup finished without result");

endmodule
